// ----- design/ccu_pkg.sv -----
package ccu_pkg;

	localparam int NUM_VARS  = 16;
	localparam int VARS_USED = (NUM_VARS > 16) ? 16 : NUM_VARS;
	localparam int CUBE_W    = 32;
	localparam int COUNT_W   = 6;
	localparam int OP_W      = 3;

	typedef enum logic [OP_W-1:0] {
		OP_SHARP = 3'd0,
		OP_ISECT = 3'd1,
		OP_SUPER = 3'd2,
		OP_COVER = 3'd3,
		OP_VALID = 3'd4
	} op_t;

	typedef logic [VARS_USED-1:0] vmask_t;
	typedef logic [CUBE_W-1:0]    cube_t;

	typedef struct packed {
		cube_t              cube;
		logic [COUNT_W-1:0] count;
		logic               valid;
		logic               none;
		logic               last;
	} res_t;

	function automatic cube_t cube_mask();
		cube_t m;
		for (int i = 0; i < CUBE_W; i++) begin
			m[i] = (i < 2 * VARS_USED);
		end
		return m;
	endfunction

	localparam cube_t CUBE_MASK = cube_mask();

	function automatic logic [3:0] popcount8(input logic [7:0] x);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'b000, x[i]};
		end
		return n;
	endfunction

	function automatic logic [COUNT_W-1:0] popcount32(input cube_t x);
		logic [COUNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < CUBE_W / 8; i++) begin
			n = n + {{(COUNT_W-4){1'b0}}, popcount8(x[8*i +: 8])};
		end
		return n;
	endfunction

endpackage

// ----- design/ccu_alu.sv -----
module ccu_alu (
	input  logic [ccu_pkg::OP_W-1:0] op,
	input  ccu_pkg::cube_t           a,
	input  ccu_pkg::cube_t           b,
	input  ccu_pkg::vmask_t          emitted,
	output ccu_pkg::res_t            res,
	output ccu_pkg::vmask_t          pick
);
	import ccu_pkg::*;

	vmask_t empty, nz, eq, eq_low, keep, rem, rest;
	cube_t  field, cand, empty_ext;
	logic   valid;

	always_comb begin
		for (int v = 0; v < VARS_USED; v++) begin
			empty[v] = (a[2*v +: 2] == 2'b00);
			nz[v]    = ((a[2*v +: 2] & ~b[2*v +: 2]) != 2'b00);
			eq[v]    = ((a[2*v +: 2] &  b[2*v +: 2]) == 2'b00);
		end
	end

	assign valid = ~|empty;

	// a candidate equal to cube A itself can come from several variables; keep the first
	assign eq_low = eq & vmask_t'(~eq + vmask_t'(1));
	assign keep   = valid ? (nz & (~eq | eq_low)) : '0;
	assign rem    = keep & ~emitted;
	assign pick   = rem & vmask_t'(~rem + vmask_t'(1));
	assign rest   = rem & ~pick;

	always_comb begin
		field     = '0;
		empty_ext = '0;
		for (int v = 0; v < VARS_USED; v++) begin
			field[2*v +: 2] = {2{pick[v]}};
			empty_ext[v]    = empty[v];
		end
	end

	assign cand = (a & ~field) | (a & ~b & field);

	always_comb begin
		res       = '0;
		res.valid = valid;
		res.last  = 1'b1;
		unique case (op)
			OP_SHARP: begin
				if (rem == '0) begin
					res.none = 1'b1;
				end else begin
					res.cube = cand;
					res.last = (rest == '0);
				end
			end
			OP_ISECT: res.cube = a & b;
			OP_SUPER: res.cube = a | b;
			OP_COVER: begin
				if ((~a & b) == '0) begin
					res.count = popcount32(a & ~b);
				end
			end
			OP_VALID: res.count = popcount32(empty_ext);
			default:  res.none = 1'b1;
		endcase
	end

endmodule

// ----- design/cube_calculus_unit_core.sv -----
// Inputs are registered in the input stage and result words in the output register.
// Unless the output stalls: one input word per cycle for intersect, supercube, coverage
// and validity, and for sharp one result word per cycle from a single emitter at the
// output register; a sharp item holds the input stage until its last word (up to 16).
// Reset clears the stage and output valid flags and the emitted-variable mask.
module cube_calculus_unit_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ccu_pkg::OP_W-1:0]       opcode,
	input  ccu_pkg::cube_t                 cube_a,
	input  ccu_pkg::cube_t                 cube_b,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ccu_pkg::cube_t                 result_cube,
	output logic [ccu_pkg::COUNT_W-1:0]    result_count,
	output logic                           cube_valid,
	output logic                           no_result,
	output logic                           last_result
);
	import ccu_pkg::*;

	logic             item_vld_s1;
	logic [OP_W-1:0]  op_s1;
	cube_t            a_s1, b_s1;
	vmask_t           emitted_q;
	logic             out_vld_q;
	res_t             res_q;

	res_t             res;
	vmask_t           pick;
	logic             out_free, emit, done, accept;

	ccu_alu u_alu (
		.op      (op_s1),
		.a       (a_s1),
		.b       (b_s1),
		.emitted (emitted_q),
		.res     (res),
		.pick    (pick)
	);

	assign out_free = !out_vld_q || out_ready;
	assign emit     = item_vld_s1 && out_free;
	assign done     = emit && res.last;
	assign in_ready = !item_vld_s1 || done;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
			emitted_q   <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (accept) begin
				item_vld_s1 <= 1'b1;
			end else if (done) begin
				item_vld_s1 <= 1'b0;
			end
			if (emit) begin
				emitted_q <= res.last ? '0 : (emitted_q | pick);
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= opcode;
			a_s1  <= cube_a & CUBE_MASK;
			b_s1  <= cube_b & CUBE_MASK;
		end
		if (emit) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_vld_q;
	assign result_cube  = res_q.cube;
	assign result_count = res_q.count;
	assign cube_valid   = res_q.valid;
	assign no_result    = res_q.none;
	assign last_result  = res_q.last;

	// emitted mask must be clean whenever no item is held
	a_clean_mask: assert property (@(posedge clk) disable iff (!arst_n)
		!item_vld_s1 |-> emitted_q == '0)
		else $error("emitted mask set with empty stage");

	// a non-final sharp word keeps the item in the stage
	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !res.last |=> item_vld_s1)
		else $error("item dropped before its last word");

	a_one_pick: assert property (@(posedge clk) disable iff (!arst_n)
		item_vld_s1 |-> $onehot0(pick))
		else $error("more than one variable picked");

	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_result |-> last_result)
		else $error("empty result not marked last");

endmodule

// ----- test/cube_calculus_unit_core_test.sv -----
`timescale 1ns / 1ps

module cube_calculus_unit_core_test;
	import ccu_pkg::*;

	typedef struct {
		logic [OP_W-1:0] op;
		cube_t           a;
		cube_t           b;
	} op_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [OP_W-1:0]    opcode = '0;
	cube_t              cube_a = '0;
	cube_t              cube_b = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	cube_t              result_cube;
	logic [COUNT_W-1:0] result_count;
	logic               cube_valid;
	logic               no_result;
	logic               last_result;

	op_word_t pending[$];
	res_t     due_results[$];
	op_word_t cur_word;
	res_t     got_word;
	res_t     want_word;
	int       errors = 0;
	int       send_wait = 0;
	int       sent_idx = 0;
	int       accepted_cnt = 0;
	int       recv_stall = 0;
	int       words_seen = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;

	cube_calculus_unit_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.cube_a       (cube_a),
		.cube_b       (cube_b),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_cube  (result_cube),
		.result_count (result_count),
		.cube_valid   (cube_valid),
		.no_result    (no_result),
		.last_result  (last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int empty_pairs(input cube_t c);
		int n;
		n = 0;
		for (int v = 0; v < VARS_USED; v++) begin
			if (c[2*v +: 2] == 2'b00) n++;
		end
		return n;
	endfunction

	// expected words for one input word, appended to due_results
	function automatic void calc_cube_results(input op_word_t w);
		cube_t am, bm, cand, field;
		cube_t kept[$];
		int    empties;
		bit    dup;
		res_t  r;
		am = w.a & CUBE_MASK;
		bm = w.b & CUBE_MASK;
		empties = empty_pairs(am);
		r.cube = '0;
		r.count = '0;
		r.valid = (empties == 0);
		r.none = 1'b0;
		r.last = 1'b1;
		case (w.op)
			OP_SHARP: begin
				for (int v = 0; v < VARS_USED; v++) begin
					field = '0;
					field[2*v +: 2] = 2'b11;
					cand = (am & ~field) | (am & ~bm & field);
					dup = 1'b0;
					foreach (kept[k]) if (kept[k] == cand) dup = 1'b1;
					if (empty_pairs(cand) == 0 && !dup) kept.push_back(cand);
				end
				if (kept.size() == 0) begin
					r.none = 1'b1;
					due_results.push_back(r);
				end else begin
					foreach (kept[k]) begin
						r.cube = kept[k];
						r.last = (k == kept.size() - 1);
						due_results.push_back(r);
					end
				end
				return;
			end
			OP_ISECT: r.cube = am & bm;
			OP_SUPER: r.cube = am | bm;
			OP_COVER: begin
				if ((~am & bm) == '0) r.count = COUNT_W'($countones(am & ~bm));
			end
			OP_VALID: r.count = COUNT_W'(empties);
			default: r.none = 1'b1;
		endcase
		due_results.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns %s: got %h want %h", $time, what, got, want);
		errors++;
	endtask

	task automatic add_word(input logic [OP_W-1:0] op, input cube_t a, input cube_t b);
		op_word_t w;
		w.op = op;
		w.a = a;
		w.b = b;
		pending.push_back(w);
	endtask

	// cube with every pair drawn from 01/10/11, or from all four when empties are allowed
	function automatic cube_t make_cube(input bit allow_empty);
		cube_t c;
		for (int v = 0; v < CUBE_W / 2; v++) begin
			c[2*v +: 2] = allow_empty ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 3));
		end
		return c;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				calc_cube_results(cur_word);
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!in_valid || in_ready) begin
				if (send_wait != 0) begin
					in_valid <= 1'b0;
					send_wait = send_wait - 1;
				end else if (pending.size() != 0) begin
					cur_word = pending.pop_front();
					opcode <= cur_word.op;
					cube_a <= cur_word.a;
					cube_b <= cur_word.b;
					in_valid <= 1'b1;
					// every third stretch of 20 words goes back to back
					send_wait = ((sent_idx / 20) % 3 == 1) ? 0 : $urandom_range(0, 18);
					sent_idx++;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// one long receiver hold-off mid-run so the core backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && accepted_cnt >= 50) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got_word.cube = result_cube;
				got_word.count = result_count;
				got_word.valid = cube_valid;
				got_word.none = no_result;
				got_word.last = last_result;
				if (due_results.size() == 0) begin
					report_mismatch("unexpected word", result_cube, '0);
				end else begin
					want_word = due_results.pop_front();
					if (got_word.cube !== want_word.cube)
						report_mismatch("result_cube", got_word.cube, want_word.cube);
					if (got_word.count !== want_word.count)
						report_mismatch("result_count", 32'(got_word.count),
							32'(want_word.count));
					if (got_word.valid !== want_word.valid)
						report_mismatch("cube_valid", 32'(got_word.valid),
							32'(want_word.valid));
					if (got_word.none !== want_word.none)
						report_mismatch("no_result", 32'(got_word.none),
							32'(want_word.none));
					if (got_word.last !== want_word.last)
						report_mismatch("last_result", 32'(got_word.last),
							32'(want_word.last));
				end
				words_seen++;
				recv_stall = ((words_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 18);
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (recv_stall != 0) begin
				out_ready <= 1'b0;
				recv_stall = recv_stall - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("cube_calculus_unit_core: mismatch");
		$finish;
	end

	initial begin
		int   pick;
		cube_t a, b;

		// sharp: all candidates equal a, one word after dedup
		add_word(OP_SHARP, '1, '0);
		// sharp: every pair cleared, nothing kept
		add_word(OP_SHARP, '1, '1);
		// sharp: sixteen distinct cubes
		add_word(OP_SHARP, '1, 32'h5555_5555);
		// sharp with an empty pair in a
		add_word(OP_SHARP, 32'hFFFF_FFF3, 32'h5555_5555);
		add_word(OP_SHARP, '0, '0);
		add_word(OP_SHARP, 32'hAAAA_AAAA, 32'h5555_5555);
		add_word(OP_SHARP, 32'h5555_5555, 32'hFFFF_FFFD);
		add_word(OP_ISECT, '1, '1);
		add_word(OP_ISECT, '0, '1);
		add_word(OP_SUPER, '0, '0);
		add_word(OP_SUPER, 32'h1234_5678, 32'h8765_4321);
		add_word(OP_COVER, '1, '0);
		add_word(OP_COVER, '0, '1);
		add_word(OP_COVER, '1, '1);
		add_word(OP_COVER, 32'hF0F0_F0F0, 32'h00F0_00F0);
		add_word(OP_VALID, '0, '1);
		add_word(OP_VALID, '1, '0);
		add_word(OP_VALID, 32'h5555_5555, '0);
		add_word(OP_VALID, 32'h0000_FFFF, '1);
		add_word(OP_VALID + 3'd1, '1, '1);
		add_word(OP_VALID + 3'd2, '0, '0);
		add_word({OP_W{1'b1}}, 32'hDEAD_BEEF, 32'hCAFE_F00D);

		for (int i = 0; i < 100; i++) begin
			pick = $urandom_range(0, 19);
			a = ($urandom_range(0, 4) != 0) ? make_cube(1'b0) : $urandom;
			if (pick < 8) begin
				case ($urandom_range(0, 2))
					0: b = make_cube(1'b1);
					1: b = $urandom;
					default: b = a & $urandom;
				endcase
				add_word(OP_SHARP, a, b);
			end else if (pick < 10) begin
				add_word(OP_ISECT, $urandom, $urandom);
			end else if (pick < 12) begin
				add_word(OP_SUPER, $urandom, $urandom);
			end else if (pick < 15) begin
				b = $urandom_range(0, 1) ? (a & $urandom) : $urandom;
				add_word(OP_COVER, a, b);
			end else if (pick < 18) begin
				add_word(OP_VALID, $urandom_range(0, 3) != 0 ? make_cube(1'b1) : $urandom,
					$urandom);
			end else begin
				add_word(OP_W'($urandom_range(OP_VALID + 1, {OP_W{1'b1}})), $urandom,
					$urandom);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("cube_calculus_unit_core: match");
		end else begin
			$display("cube_calculus_unit_core: mismatch");
		end
		$finish;
	end

endmodule
